// File: sv/frcc_pkg.sv
// Shared constants, types and codes of the fractional clock rate converter.
package frcc_pkg;

    localparam int CYC_W           = 11;
    localparam int SYS_W           = 22;
    localparam int CPU_W           = 27;
    localparam int NUM_W           = 33;
    localparam int TICK_W          = 32;
    localparam int ACC_W           = 33;
    localparam int SLOW_W          = 3;
    localparam int FRAME_W         = 10;
    localparam int MAX_STEP_CYCLES = 1024;

    localparam int MUL_STEPS = CYC_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CPU_W;

    localparam logic [CFG_IDX_W-1:0] REG_CPU_HZ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYS_HZ = 2'd1;

    localparam logic [CPU_W-1:0] CPU_HZ_RESET = 27'd4772727;
    localparam logic [SYS_W-1:0] SYS_HZ_RESET = 22'd1193182;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SLOW,
        ST_FRAME
    } t_state;

    typedef struct packed {
        logic [TICK_W-1:0] sys_ticks;
        logic              slow_fire;
        logic [ACC_W-1:0]  slow_ticks;
        logic              frame_fire;
        logic [ACC_W-1:0]  frame_ticks;
    } t_result;

endpackage

// File: sv/frcc_chan_if.sv
// Request, result and register write channels of the converter.
interface frcc_req_if;
    import frcc_pkg::*;
    logic             valid;
    logic             ready;
    logic [CYC_W-1:0] cpu_cycles;
    modport source (output valid, output cpu_cycles, input ready);
    modport sink (input valid, input cpu_cycles, output ready);
endinterface

interface frcc_rsp_if;
    import frcc_pkg::*;
    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] sys_ticks;
    logic              slow_fire;
    logic [ACC_W-1:0]  slow_ticks;
    logic              frame_fire;
    logic [ACC_W-1:0]  frame_ticks;
    modport source (output valid, output sys_ticks, output slow_fire, output slow_ticks,
                    output frame_fire, output frame_ticks, input ready);
    modport sink (input valid, input sys_ticks, input slow_fire, input slow_ticks,
                  input frame_fire, input frame_ticks, output ready);
endinterface

interface frcc_cfg_if;
    import frcc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/fractional_clock_rate_converter.sv
// Top level of the fractional clock rate converter.
//  channel | dir | handshake     | payload
//  i_req   | in  | valid/ready   | cpu_cycles
//  o_rsp   | out | valid/ready   | sys_ticks, slow_fire, slow_ticks, frame_fire, frame_ticks
//  i_cfg   | in  | valid/ready   | index, data (0 cpu_clock_hz, 1 sys_clock_hz)
// A request runs through the bit-serial multiply and the bit-serial divide, with a registered
// hand-off after each, and then through the two accumulator stages to the output register.
// The next request is taken once the result sits in the output register.
// A stalled result holds the last stage until the output register frees up.
// Reset is synchronous; registers return to their default rates, state to zero.
module fractional_clock_rate_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frcc_req_if.sink    i_req,
    frcc_rsp_if.source  o_rsp,
    frcc_cfg_if.sink    i_cfg
);
    import frcc_pkg::*;

    t_state           r_state, n_state;
    logic [CPU_W-1:0] r_cpu_hz;
    logic [SYS_W-1:0] r_sys_hz;
    logic [CPU_W-1:0] r_rem;
    logic             r_out_valid, n_out_valid;
    t_result          r_out;
    t_result          w_result;
    logic             w_accept;
    logic             w_mul_done;
    logic             w_div_done;
    logic [NUM_W-1:0] w_num;
    logic [NUM_W-1:0] w_quot;
    logic [CPU_W-1:0] w_div_rem;
    logic             w_commit;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_hz <= CPU_HZ_RESET;
            r_sys_hz <= SYS_HZ_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_CPU_HZ: r_cpu_hz <= i_cfg.data;
                REG_SYS_HZ: r_sys_hz <= i_cfg.data[SYS_W-1:0];
                default: ;
            endcase
        end
    end

    frcc_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_cycles (i_req.cpu_cycles),
        .i_sys_hz (r_sys_hz),
        .i_rem    (r_rem),
        .o_done   (w_mul_done),
        .o_num    (w_num)
    );

    frcc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_done),
        .i_num    (w_num),
        .i_cpu_hz (r_cpu_hz),
        .o_done   (w_div_done),
        .o_quot   (w_quot),
        .o_rem    (w_div_rem)
    );

    frcc_acc u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_div_done),
        .i_ticks  (w_quot),
        .i_commit (w_commit),
        .o_result (w_result)
    );

    always_comb begin
        n_state     = r_state;
        w_commit    = 1'b0;
        n_out_valid = r_out_valid && !o_rsp.ready;
        unique case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_MUL;
            ST_MUL:   if (w_mul_done) n_state = ST_DIV;
            ST_DIV:   if (w_div_done) n_state = ST_SLOW;
            ST_SLOW:  n_state = ST_FRAME;
            ST_FRAME: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_commit    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_rem       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_div_done) begin
                r_rem <= w_div_rem;
            end
        end
        if (w_commit) begin
            r_out <= w_result;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.sys_ticks   = r_out.sys_ticks;
    assign o_rsp.slow_fire   = r_out.slow_fire;
    assign o_rsp.slow_ticks  = r_out.slow_ticks;
    assign o_rsp.frame_fire  = r_out.frame_fire;
    assign o_rsp.frame_ticks = r_out.frame_ticks;

    a_mul_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> r_state == ST_MUL)
        else $error("multiply finished outside its state");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_DIV)
        else $error("divide finished outside its state");

    a_frame_needs_slow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.frame_fire |-> o_rsp.slow_fire)
        else $error("frame stage fired without slow stage");

    a_slow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.slow_fire |-> o_rsp.slow_ticks == '0)
        else $error("slow ticks nonzero without fire");

    a_commit_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid && r_state == ST_IDLE)
        else $error("commit did not load the output register");

endmodule

// File: sv/frcc_mul.sv
// Bit-serial shift-add multiplier: cycles times rate plus carried remainder.
module frcc_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [frcc_pkg::CYC_W-1:0]  i_cycles,
    input  logic [frcc_pkg::SYS_W-1:0]  i_sys_hz,
    input  logic [frcc_pkg::CPU_W-1:0]  i_rem,
    output logic                        o_done,
    output logic [frcc_pkg::NUM_W-1:0]  o_num
);
    import frcc_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [MUL_CNT_W-1:0] r_cnt, n_cnt;
    logic [CYC_W-1:0]     r_mplier, n_mplier;
    logic [NUM_W-1:0]     r_mcand, n_mcand;
    logic [NUM_W-1:0]     r_prod, n_prod;
    logic [CYC_W-1:0]     w_cycles;

    always_comb begin
        w_cycles = (i_cycles > CYC_W'(MAX_STEP_CYCLES)) ? CYC_W'(MAX_STEP_CYCLES) : i_cycles;
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_mplier = r_mplier;
        n_mcand  = r_mcand;
        n_prod   = r_prod;
        if (i_start) begin
            n_busy   = 1'b1;
            n_cnt    = '0;
            n_mplier = w_cycles;
            n_mcand  = {{(NUM_W-SYS_W){1'b0}}, i_sys_hz};
            n_prod   = {{(NUM_W-CPU_W){1'b0}}, i_rem};
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                n_prod = r_prod + r_mcand;
            end
            n_mcand  = {r_mcand[NUM_W-2:0], 1'b0};
            n_mplier = {1'b0, r_mplier[CYC_W-1:1]};
            n_cnt    = r_cnt + 1'b1;
            if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_mplier <= n_mplier;
        r_mcand  <= n_mcand;
        r_prod   <= n_prod;
    end

    assign o_done = r_done;
    assign o_num  = r_prod;

endmodule

// File: sv/frcc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module frcc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [frcc_pkg::NUM_W-1:0]  i_num,
    input  logic [frcc_pkg::CPU_W-1:0]  i_cpu_hz,
    output logic                        o_done,
    output logic [frcc_pkg::NUM_W-1:0]  o_quot,
    output logic [frcc_pkg::CPU_W-1:0]  o_rem
);
    import frcc_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0]     r_num, n_num;
    logic [CPU_W-1:0]     r_prem, n_prem;
    logic [CPU_W-1:0]     r_dvsr, n_dvsr;
    logic [CPU_W:0]       w_trial;
    logic [CPU_W:0]       w_diff;
    logic                 w_ge;

    always_comb begin
        w_trial = {r_prem, r_num[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_dvsr};
        w_ge    = w_trial >= {1'b0, r_dvsr};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_num   = r_num;
        n_prem  = r_prem;
        n_dvsr  = r_dvsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_num;
            n_prem = '0;
            n_dvsr = (i_cpu_hz == '0) ? CPU_W'(1) : i_cpu_hz;
        end else if (r_busy) begin
            n_prem = w_ge ? w_diff[CPU_W-1:0] : w_trial[CPU_W-1:0];
            n_num  = {r_num[NUM_W-2:0], w_ge};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num  <= n_num;
        r_prem <= n_prem;
        r_dvsr <= n_dvsr;
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_prem;

endmodule

// File: sv/frcc_acc.sv
// Divide-by-8 and divide-by-1024 tick accumulators.
module frcc_acc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [frcc_pkg::NUM_W-1:0]  i_ticks,
    input  logic                        i_commit,
    output frcc_pkg::t_result           o_result
);
    import frcc_pkg::*;

    logic [SLOW_W-1:0]  r_slow;
    logic [FRAME_W-1:0] r_frame;
    logic [TICK_W-1:0]  r_ticks;
    logic [ACC_W-1:0]   r_sum;
    logic [TICK_W-1:0]  w_sat;
    logic [ACC_W-1:0]   w_frame_sum;
    logic               w_slow_fire;
    logic               w_frame_fire;

    always_comb begin
        w_sat        = i_ticks[NUM_W-1] ? '1 : i_ticks[TICK_W-1:0];
        w_frame_sum  = {{(ACC_W-FRAME_W){1'b0}}, r_frame} + r_sum;
        w_slow_fire  = |r_sum[ACC_W-1:SLOW_W];
        w_frame_fire = w_slow_fire && (|w_frame_sum[ACC_W-1:FRAME_W]);
        o_result.sys_ticks   = r_ticks;
        o_result.slow_fire   = w_slow_fire;
        o_result.slow_ticks  = w_slow_fire ? {r_sum[ACC_W-1:SLOW_W], {SLOW_W{1'b0}}} : '0;
        o_result.frame_fire  = w_frame_fire;
        o_result.frame_ticks = w_frame_fire ?
                               {w_frame_sum[ACC_W-1:FRAME_W], {FRAME_W{1'b0}}} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow  <= '0;
            r_frame <= '0;
        end else if (i_commit) begin
            r_slow <= r_sum[SLOW_W-1:0];
            if (w_slow_fire) begin
                r_frame <= w_frame_sum[FRAME_W-1:0];
            end
        end
        if (i_load) begin
            r_ticks <= w_sat;
            r_sum   <= {{(ACC_W-SLOW_W){1'b0}}, r_slow} + {{(ACC_W-TICK_W){1'b0}}, w_sat};
        end
    end

endmodule
